[src/cbp_pkg.sv]
// Shared constants and types for the chain bottleneck partition unit.
package cbp_pkg;

    localparam int MAX_TASKS   = 1024;
    localparam int MAX_WORKERS = 16;

    localparam int TADDR_W = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int WIDX_W  = 4;
    localparam int WCNT_W  = 5;
    localparam int COST_W  = 27;
    localparam int TIME_W  = 16;

    localparam logic [COST_W-1:0] COST_INF = '1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ROW  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_EV   = 7'b0001000,
        S_WR   = 7'b0010000,
        S_ERD  = 7'b0100000,
        S_EOUT = 7'b1000000
    } state_t;

endpackage

[src/chain_bottleneck_partition_unit.sv]
// Chain bottleneck partition: min-max split of a task chain over workers.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  task in   | start, busy, task_time, last_task         | in (busy out)
//  result    | result_valid, segment_length, worker_index,| out
//            | last_segment                              |
//  config    | psel, penable, pwrite, paddr, pwdata,     | APB
//            | prdata, pready                            |
//
// A non-final task is stored (while fewer than MAX_TASKS are held); busy stays low.
// After the final task the table fill runs column by column, each row
// scanning all split points with one shared add/compare unit, with one
// task-store read per split.
// Results then follow, each after a length table read, m of them.
// No clearing pass after reset. The result side cannot stall.
module chain_bottleneck_partition_unit
    import cbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [TIME_W-1:0]    task_time,
    input  logic                 last_task,
    output logic                 result_valid,
    output logic [10:0]          segment_length,
    output logic [WIDX_W-1:0]    worker_index,
    output logic                 last_segment,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [TIME_W-1:0]  task_mem [MAX_TASKS];
    logic [COST_W-1:0]  cost_mem [2*MAX_TASKS];
    logic [CNT_W-1:0]   len_mem  [MAX_WORKERS*MAX_TASKS];

    state_t             state_reg, state_next;
    logic [WCNT_W-1:0]  wcount_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIDX_W-1:0]  j_reg, j_next;
    logic [TADDR_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [COST_W-1:0]  run_reg, run_next;
    logic [COST_W-1:0]  best_reg, best_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [WIDX_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;

    logic [TIME_W-1:0]  task_rd;
    logic [COST_W-1:0]  cost_rd;
    logic [CNT_W-1:0]   len_rd;

    logic [WCNT_W-1:0]  m_eff;
    logic               accept;
    logic               store_ok;
    logic               j_last;
    logic [COST_W-1:0]  rest, cand;
    logic [CNT_W-1:0]   out_len;

    assign pready = 1'b1;
    assign prdata = {{(32-WCNT_W){1'b0}}, wcount_reg};

    always_comb
    begin
        if (wcount_reg == '0)
            m_eff = WCNT_W'(1);
        else if (wcount_reg > WCNT_W'(MAX_WORKERS))
            m_eff = WCNT_W'(MAX_WORKERS);
        else
            m_eff = wcount_reg;
    end

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign store_ok = (count_reg < CNT_W'(MAX_TASKS));
    assign j_last   = ({1'b0, j_reg} + WCNT_W'(1)) == m_eff;

    // split-point evaluation: bottleneck of this segment vs. best of the rest
    always_comb
    begin
        if (k_reg == count_reg)
            rest = '0;
        else if (j_last)
            rest = COST_INF;
        else
            rest = cost_rd;
        cand = (run_reg > rest) ? run_reg : rest;
    end

    assign out_len        = (pos_reg < count_reg) ? len_rd : '0;
    assign result_valid   = (state_reg == S_EOUT);
    assign segment_length = out_len;
    assign worker_index   = w_reg;
    assign last_segment   = ({1'b0, w_reg} + WCNT_W'(1)) == m_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wcount_reg <= WCNT_W'(1);
        else if (psel && penable && pwrite && pready)
            wcount_reg <= pwdata[WCNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
            task_mem[count_reg[TADDR_W-1:0]] <= task_time;
        task_rd <= task_mem[k_reg[TADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
            cost_mem[{j_reg[0], i_reg}] <= best_reg;
        cost_rd <= cost_mem[{~j_reg[0], k_reg[TADDR_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
            len_mem[{j_reg, i_reg}] <= len_reg;
        len_rd <= len_mem[{w_reg, pos_reg[TADDR_W-1:0]}];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        run_next   = run_reg;
        best_next  = best_reg;
        len_next   = len_reg;
        w_next     = w_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok)
                        count_next = count_reg + CNT_W'(1);
                    if (last_task)
                    begin
                        j_next     = WIDX_W'(m_eff - WCNT_W'(1));
                        i_next     = TADDR_W'(count_next - CNT_W'(1));
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW:
            begin
                k_next     = {1'b0, i_reg};
                run_next   = '0;
                best_next  = COST_INF;
                len_next   = '0;
                state_next = S_RD;
            end
            S_RD:
                state_next = S_EV;
            S_EV:
            begin
                // strict less: the shortest best segment is kept
                if (cand < best_reg)
                begin
                    best_next = cand;
                    len_next  = k_reg - {1'b0, i_reg};
                end
                if (k_reg == count_reg)
                    state_next = S_WR;
                else
                begin
                    run_next   = run_reg + COST_W'(task_rd);
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_RD;
                end
            end
            S_WR:
            begin
                if (i_reg == '0)
                begin
                    if (j_reg == '0)
                    begin
                        w_next     = '0;
                        pos_next   = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        j_next     = j_reg - WIDX_W'(1);
                        i_next     = TADDR_W'(count_reg - CNT_W'(1));
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    i_next     = i_reg - TADDR_W'(1);
                    state_next = S_ROW;
                end
            end
            S_ERD:
                state_next = S_EOUT;
            S_EOUT:
            begin
                pos_next = pos_reg + out_len;
                if (last_segment)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next     = w_reg + WIDX_W'(1);
                    state_next = S_ERD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        run_reg  <= run_next;
        best_reg <= best_next;
        len_reg  <= len_next;
        w_reg    <= w_next;
        pos_reg  <= pos_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above store depth");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_task |=> busy)
        else $error("final task did not start computation");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside computation");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_segment |=> !busy && count_reg == '0)
        else $error("block not idle after final result");

endmodule
